>>> sv/dema_pkg.sv
// shared constants, types and register codes for the dual average noise classifier
package dema_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int FRACTION_BITS = 16;
  localparam int AVG_BITS      = SAMPLE_BITS + FRACTION_BITS;

  localparam int ALPHA_BITS  = 17;
  localparam int ALPHA_FRAC  = 16;
  localparam int THRESH_BITS = 16;
  localparam int THRESH_FRAC = 8;
  localparam int LEVEL_BITS  = 2;

  // shared signed multiplier: alpha or threshold times difference or baseline
  localparam int MUL_A_BITS = ALPHA_BITS + 1;
  localparam int MUL_B_BITS = AVG_BITS + 1;
  localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;
  localparam int CMP_BITS   = THRESH_BITS + AVG_BITS;

  localparam int CFG_DATA_BITS  = ALPHA_BITS;
  localparam int CFG_INDEX_BITS = 3;

  // depth must be a power of two so the pointers wrap on their own
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_INDEX_BITS-1:0] REG_FAST_ALPHA        = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SLOW_ALPHA        = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_REGULAR_THRESHOLD = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_THRESHOLD    = CFG_INDEX_BITS'(3);
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOXIC_THRESHOLD   = CFG_INDEX_BITS'(4);

  localparam logic [ALPHA_BITS-1:0]  FAST_ALPHA_RESET        = ALPHA_BITS'(6554);
  localparam logic [ALPHA_BITS-1:0]  SLOW_ALPHA_RESET        = ALPHA_BITS'(66);
  localparam logic [THRESH_BITS-1:0] REGULAR_THRESHOLD_RESET = THRESH_BITS'(307);
  localparam logic [THRESH_BITS-1:0] HIGH_THRESHOLD_RESET    = THRESH_BITS'(384);
  localparam logic [THRESH_BITS-1:0] TOXIC_THRESHOLD_RESET   = THRESH_BITS'(512);

  localparam logic [LEVEL_BITS-1:0] LEVEL_OK       = LEVEL_BITS'(0);
  localparam logic [LEVEL_BITS-1:0] LEVEL_REGULAR  = LEVEL_BITS'(1);
  localparam logic [LEVEL_BITS-1:0] LEVEL_ELEVATED = LEVEL_BITS'(2);
  localparam logic [LEVEL_BITS-1:0] LEVEL_CRITICAL = LEVEL_BITS'(3);

  typedef struct packed {
    logic [ALPHA_BITS-1:0]  fast_alpha;
    logic [ALPHA_BITS-1:0]  slow_alpha;
    logic [THRESH_BITS-1:0] regular_threshold;
    logic [THRESH_BITS-1:0] high_threshold;
    logic [THRESH_BITS-1:0] toxic_threshold;
  } cfg_t;

  // sample already scaled to the average's fixed point
  typedef struct packed {
    logic [AVG_BITS-1:0] x;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> sv/dema_if.sv
// handshake channels for samples and classification results
interface dema_in_if;
  logic                             valid;
  logic                             ready;
  logic [dema_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface dema_out_if;
  logic                            valid;
  logic                            ready;
  logic [dema_pkg::LEVEL_BITS-1:0] level;
  logic [dema_pkg::AVG_BITS-1:0]   fast_average;
  logic [dema_pkg::AVG_BITS-1:0]   baseline_average;

  modport source (output valid, output level, output fast_average,
                  output baseline_average, input ready);
  modport sink (input valid, input level, input fast_average,
                input baseline_average, output ready);
endinterface

>>> sv/dema_front.sv
// front stage: takes samples, scales them to fixed point and feeds the queue
module dema_front (
  input  logic                    clk,
  input  logic                    rst,
  dema_in_if.sink                 samples,
  input  dema_pkg::queue_status_t qstat,
  output logic                    push,
  output dema_pkg::item_t         push_item
);

  logic            held;
  dema_pkg::item_t item;

  assign push          = held && !qstat.full;
  assign push_item     = item;
  assign samples.ready = !held || push;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
    if (samples.valid && samples.ready) begin
      item.x <= {samples.sample, {dema_pkg::FRACTION_BITS{1'b0}}};
    end
  end

endmodule

>>> sv/dema_queue.sv
// short item queue between the front stage and the arithmetic sequencer
module dema_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  dema_pkg::item_t         push_item,
  input  logic                    pop,
  output dema_pkg::item_t         pop_item,
  output dema_pkg::queue_status_t status
);

  dema_pkg::item_t                        mem [dema_pkg::QUEUE_DEPTH];
  logic [dema_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr;
  logic [dema_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr;
  logic [dema_pkg::QUEUE_PTR_BITS:0]      count;

  assign status.full  = count == (dema_pkg::QUEUE_PTR_BITS + 1)'(dema_pkg::QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign pop_item     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

>>> sv/dema_back.sv
// back end: updates both averages and classifies the ratio on one shared multiplier
module dema_back (
  input  logic                    clk,
  input  logic                    rst,
  input  dema_pkg::cfg_t          cfg,
  input  dema_pkg::queue_status_t qstat,
  input  dema_pkg::item_t         pop_item,
  output logic                    pop,
  dema_out_if.source              results
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FAST,
    S_SLOW,
    S_SLOW_UPD,
    S_CMP_REG,
    S_CMP_HIGH,
    S_CMP_TOXIC,
    S_DONE
  } state_t;

  localparam logic [dema_pkg::ALPHA_BITS-1:0] ALPHA_ONE =
    dema_pkg::ALPHA_BITS'(1) << dema_pkg::ALPHA_FRAC;
  localparam logic signed [dema_pkg::MUL_P_BITS-1:0] ROUND_HALF =
    dema_pkg::MUL_P_BITS'(1) << (dema_pkg::ALPHA_FRAC - 1);

  state_t                                  state;
  logic [dema_pkg::AVG_BITS-1:0]           x;
  logic [dema_pkg::AVG_BITS-1:0]           fast_avg;
  logic [dema_pkg::AVG_BITS-1:0]           slow_avg;
  logic signed [dema_pkg::MUL_P_BITS-1:0]  prod;
  logic [1:0]                              below;
  logic                                    out_valid;
  logic [dema_pkg::LEVEL_BITS-1:0]         out_level;
  logic [dema_pkg::AVG_BITS-1:0]           out_fast;
  logic [dema_pkg::AVG_BITS-1:0]           out_slow;

  logic signed [dema_pkg::MUL_A_BITS-1:0]  mul_a;
  logic signed [dema_pkg::MUL_B_BITS-1:0]  mul_b;
  logic signed [dema_pkg::MUL_P_BITS-1:0]  mul_p;
  logic [dema_pkg::CMP_BITS-1:0]           fast_scaled;
  logic                                    lt;
  logic                                    out_load;
  logic [dema_pkg::LEVEL_BITS-1:0]         level_next;

  function automatic logic signed [dema_pkg::MUL_A_BITS-1:0] sat_alpha(
    input logic [dema_pkg::ALPHA_BITS-1:0] a
  );
    logic [dema_pkg::ALPHA_BITS-1:0] s;
    s = (a > ALPHA_ONE) ? ALPHA_ONE : a;
    return $signed({1'b0, s});
  endfunction

  function automatic logic signed [dema_pkg::MUL_B_BITS-1:0] diff(
    input logic [dema_pkg::AVG_BITS-1:0] sx,
    input logic [dema_pkg::AVG_BITS-1:0] avg
  );
    return $signed({1'b0, sx}) - $signed({1'b0, avg});
  endfunction

  // avg + round_half_up(alpha * (x - avg) / 2^16), stays between x and avg
  function automatic logic [dema_pkg::AVG_BITS-1:0] blend(
    input logic [dema_pkg::AVG_BITS-1:0]          avg,
    input logic signed [dema_pkg::MUL_P_BITS-1:0] p
  );
    logic signed [dema_pkg::MUL_P_BITS-1:0] step;
    logic signed [dema_pkg::MUL_P_BITS-1:0] sum;
    step = (p + ROUND_HALF) >>> dema_pkg::ALPHA_FRAC;
    sum  = $signed({{(dema_pkg::MUL_P_BITS - dema_pkg::AVG_BITS){1'b0}}, avg}) + step;
    return sum[dema_pkg::AVG_BITS-1:0];
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_FAST: begin
        mul_a = sat_alpha(cfg.fast_alpha);
        mul_b = diff(x, fast_avg);
      end
      S_SLOW: begin
        mul_a = sat_alpha(cfg.slow_alpha);
        mul_b = diff(x, slow_avg);
      end
      S_CMP_REG: begin
        mul_a = $signed({2'b00, cfg.regular_threshold});
        mul_b = $signed({1'b0, slow_avg});
      end
      S_CMP_HIGH: begin
        mul_a = $signed({2'b00, cfg.high_threshold});
        mul_b = $signed({1'b0, slow_avg});
      end
      S_CMP_TOXIC: begin
        mul_a = $signed({2'b00, cfg.toxic_threshold});
        mul_b = $signed({1'b0, slow_avg});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p       = mul_a * mul_b;
  // ratio below threshold exactly when fast * 256 < threshold * baseline
  assign fast_scaled = dema_pkg::CMP_BITS'({fast_avg, {dema_pkg::THRESH_FRAC{1'b0}}});
  assign lt          = fast_scaled < prod[dema_pkg::CMP_BITS-1:0];
  assign out_load    = (state == S_DONE) && (!out_valid || results.ready);
  assign pop         = (state == S_IDLE) && !qstat.empty;

  always_comb begin
    if (below[0]) begin
      level_next = dema_pkg::LEVEL_OK;
    end else if (below[1]) begin
      level_next = dema_pkg::LEVEL_REGULAR;
    end else if (lt) begin
      level_next = dema_pkg::LEVEL_ELEVATED;
    end else begin
      level_next = dema_pkg::LEVEL_CRITICAL;
    end
  end

  assign results.valid            = out_valid;
  assign results.level            = out_level;
  assign results.fast_average     = out_fast;
  assign results.baseline_average = out_slow;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fast_avg  <= '0;
      slow_avg  <= '0;
      out_valid <= 1'b0;
    end else begin
      // the toxic product must survive a stalled result
      if (state != S_DONE) begin
        prod <= mul_p;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            x     <= pop_item.x;
            state <= S_FAST;
          end
        end
        S_FAST: begin
          state <= S_SLOW;
        end
        S_SLOW: begin
          fast_avg <= blend(fast_avg, prod);
          state    <= S_SLOW_UPD;
        end
        S_SLOW_UPD: begin
          slow_avg <= blend(slow_avg, prod);
          state    <= S_CMP_REG;
        end
        S_CMP_REG: begin
          state <= S_CMP_HIGH;
        end
        S_CMP_HIGH: begin
          below[0] <= lt;
          state    <= S_CMP_TOXIC;
        end
        S_CMP_TOXIC: begin
          below[1] <= lt;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
        out_level <= level_next;
        out_fast  <= fast_avg;
        out_slow  <= slow_avg;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_fast_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_SLOW) |=> $stable(fast_avg))
    else $error("fast average changed outside its update step");

  a_slow_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_SLOW_UPD) |=> $stable(slow_avg))
    else $error("baseline average changed outside its update step");

  a_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_FAST) |-> $past(pop))
    else $error("sequence started without taking an item from the queue");

  a_finish: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == S_IDLE))
    else $error("finished item not presented on the result channel");
`endif

endmodule

>>> sv/dual_ema_noise_level_classifier.sv
// top level: config registers, front stage, item queue and arithmetic back end
//
//   channel    dir  handshake             payload
//   samples    in   valid / ready         sample [11:0]
//   results    out  valid / ready         level [1:0], fast_average [27:0],
//                                         baseline_average [27:0]
//   config     in   wr_en (no wait)       wr_index [2:0], wr_data [16:0]
//
// the back end handles one item at a time: five products run in turn through one
// shared 18 x 29 signed multiplier, plus the pop and the result load.
// samples are taken every cycle until the front register and the two-entry
// queue are full; a stalled result holds the back end in its last step.
// rst is synchronous: averages clear, registers return to their defaults.
module dual_ema_noise_level_classifier (
  input  logic                                  clk,
  input  logic                                  rst,
  dema_in_if.sink                               samples,
  dema_out_if.source                            results,
  input  logic                                  wr_en,
  input  logic [dema_pkg::CFG_INDEX_BITS-1:0]   wr_index,
  input  logic [dema_pkg::CFG_DATA_BITS-1:0]    wr_data
);

  dema_pkg::cfg_t          cfg;
  dema_pkg::queue_status_t qstat;
  dema_pkg::item_t         push_item;
  dema_pkg::item_t         pop_item;
  logic                    push;
  logic                    pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_alpha        <= dema_pkg::FAST_ALPHA_RESET;
      cfg.slow_alpha        <= dema_pkg::SLOW_ALPHA_RESET;
      cfg.regular_threshold <= dema_pkg::REGULAR_THRESHOLD_RESET;
      cfg.high_threshold    <= dema_pkg::HIGH_THRESHOLD_RESET;
      cfg.toxic_threshold   <= dema_pkg::TOXIC_THRESHOLD_RESET;
    end else if (wr_en) begin
      case (wr_index)
        dema_pkg::REG_FAST_ALPHA: begin
          cfg.fast_alpha <= wr_data[dema_pkg::ALPHA_BITS-1:0];
        end
        dema_pkg::REG_SLOW_ALPHA: begin
          cfg.slow_alpha <= wr_data[dema_pkg::ALPHA_BITS-1:0];
        end
        dema_pkg::REG_REGULAR_THRESHOLD: begin
          cfg.regular_threshold <= wr_data[dema_pkg::THRESH_BITS-1:0];
        end
        dema_pkg::REG_HIGH_THRESHOLD: begin
          cfg.high_threshold <= wr_data[dema_pkg::THRESH_BITS-1:0];
        end
        dema_pkg::REG_TOXIC_THRESHOLD: begin
          cfg.toxic_threshold <= wr_data[dema_pkg::THRESH_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  dema_front u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  dema_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (qstat)
  );

  dema_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .qstat    (qstat),
    .pop_item (pop_item),
    .pop      (pop),
    .results  (results)
  );

endmodule

>>> test/tb_top.sv
// testbench for the dual average noise level classifier: predicts every result and checks it
`timescale 1ns / 100ps

module tb_top;
  import dema_pkg::*;

  localparam int LONG_HOLD   = 64;
  localparam int SETTLE      = 16;
  localparam int STALL_LIMIT = 1000;
  localparam int MAX_REPORTS = 50;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic [AVG_BITS-1:0]   fast_average;
    logic [AVG_BITS-1:0]   baseline_average;
  } level_result_t;

  class level_checker;
    cfg_t                cfg;
    logic [AVG_BITS-1:0] fast_avg;
    logic [AVG_BITS-1:0] slow_avg;
    level_result_t       expected_levels[$];
    int                  errors;

    function new();
      cfg.fast_alpha        = FAST_ALPHA_RESET;
      cfg.slow_alpha        = SLOW_ALPHA_RESET;
      cfg.regular_threshold = REGULAR_THRESHOLD_RESET;
      cfg.high_threshold    = HIGH_THRESHOLD_RESET;
      cfg.toxic_threshold   = TOXIC_THRESHOLD_RESET;
      fast_avg = '0;
      slow_avg = '0;
      errors   = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_FAST_ALPHA:        cfg.fast_alpha = data;
        REG_SLOW_ALPHA:        cfg.slow_alpha = data;
        REG_REGULAR_THRESHOLD: cfg.regular_threshold = data[THRESH_BITS-1:0];
        REG_HIGH_THRESHOLD:    cfg.high_threshold = data[THRESH_BITS-1:0];
        REG_TOXIC_THRESHOLD:   cfg.toxic_threshold = data[THRESH_BITS-1:0];
        default: ;
      endcase
    endfunction

    // avg' = (a*x + (1-a)*avg + half) >> 16, alpha saturated at one
    function logic [AVG_BITS-1:0] smooth(logic [AVG_BITS-1:0] avg, logic [AVG_BITS-1:0] x,
                                         logic [ALPHA_BITS-1:0] alpha);
      logic [63:0] a;
      logic [63:0] acc;
      a = (alpha > ALPHA_BITS'(65536)) ? 64'd65536 : 64'(alpha);
      acc = a * 64'(x) + (64'd65536 - a) * 64'(avg) + 64'd32768;
      return acc[ALPHA_FRAC +: AVG_BITS];
    endfunction

    function bit ratio_below(logic [THRESH_BITS-1:0] thr);
      logic [63:0] lhs;
      logic [63:0] rhs;
      lhs = 64'(fast_avg) << THRESH_FRAC;
      rhs = 64'(thr) * 64'(slow_avg);
      return lhs < rhs;
    endfunction

    function void note_sample(logic [SAMPLE_BITS-1:0] sample);
      logic [AVG_BITS-1:0] x;
      level_result_t       res;
      x = AVG_BITS'(sample) << FRACTION_BITS;
      fast_avg = smooth(fast_avg, x, cfg.fast_alpha);
      slow_avg = smooth(slow_avg, x, cfg.slow_alpha);
      if (ratio_below(cfg.regular_threshold)) res.level = LEVEL_OK;
      else if (ratio_below(cfg.high_threshold)) res.level = LEVEL_REGULAR;
      else if (ratio_below(cfg.toxic_threshold)) res.level = LEVEL_ELEVATED;
      else res.level = LEVEL_CRITICAL;
      res.fast_average     = fast_avg;
      res.baseline_average = slow_avg;
      expected_levels.insert(expected_levels.size(), res);
    endfunction

    function void check_result(level_result_t got);
      level_result_t want;
      bit            bad;
      if (expected_levels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $error("result with no pending item");
        return;
      end
      want = expected_levels.pop_front();
      bad = 1'b0;
      if (got.level !== want.level) begin
        bad = 1'b1;
        if (errors < MAX_REPORTS)
          $error("level: expected %0d, got %0d", want.level, got.level);
      end
      if (got.fast_average !== want.fast_average) begin
        bad = 1'b1;
        if (errors < MAX_REPORTS)
          $error("fast_average: expected %0h, got %0h", want.fast_average, got.fast_average);
      end
      if (got.baseline_average !== want.baseline_average) begin
        bad = 1'b1;
        if (errors < MAX_REPORTS)
          $error("baseline_average: expected %0h, got %0h", want.baseline_average,
                 got.baseline_average);
      end
      if (bad) errors++;
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      wr_en;
  logic [CFG_INDEX_BITS-1:0] wr_index;
  logic [CFG_DATA_BITS-1:0]  wr_data;

  dema_in_if  samples_if ();
  dema_out_if results_if ();

  dual_ema_noise_level_classifier dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples_if),
    .results  (results_if),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  level_checker chk;
  bit           tx_idle_en = 1'b1;
  bit           rx_idle_en = 1'b1;
  bit           long_hold_req = 1'b0;
  int           stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    results_if.ready = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        results_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        results_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        results_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && chk != null) begin
      if (samples_if.valid && samples_if.ready) chk.note_sample(samples_if.sample);
      if (results_if.valid && results_if.ready)
        chk.check_result({results_if.level, results_if.fast_average,
                          results_if.baseline_average});
    end
  end

  always @(posedge clk) begin
    if (rst || wr_en || (samples_if.valid && samples_if.ready) ||
        (results_if.valid && results_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      samples_if.valid  <= 1'b0;
      samples_if.sample <= SAMPLE_BITS'($urandom);
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    samples_if.valid  <= 1'b1;
    samples_if.sample <= s;
    do @(posedge clk); while (!samples_if.ready);
  endtask

  // stop offering and wait until every predicted item has come out
  task automatic drain();
    samples_if.valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // wr_en stays high across back-to-back writes
  task automatic reg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    chk.set_register(idx, data);
  endtask

  task automatic program_regs(input logic [CFG_DATA_BITS-1:0] fa, sa, rt, ht, tt);
    reg_write(REG_FAST_ALPHA, fa);
    reg_write(REG_SLOW_ALPHA, sa);
    reg_write(REG_REGULAR_THRESHOLD, rt);
    reg_write(REG_HIGH_THRESHOLD, ht);
    reg_write(REG_TOXIC_THRESHOLD, tt);
    // unused index, must leave everything alone
    reg_write(REG_TOXIC_THRESHOLD + CFG_INDEX_BITS'($urandom_range(1, 3)),
              CFG_DATA_BITS'($urandom));
    wr_en <= 1'b0;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] clamp_sample(int v);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return SAMPLE_BITS'(v);
  endfunction

  task automatic random_config();
    logic [CFG_DATA_BITS-1:0] fa, sa, rt, ht, tt;
    int pick;
    pick = $urandom_range(0, 15);
    if (pick < 2) fa = CFG_DATA_BITS'(65536);
    else if (pick < 4) fa = CFG_DATA_BITS'($urandom_range(65537, 131071));
    else if (pick == 4) fa = '0;
    else fa = CFG_DATA_BITS'($urandom_range(1000, 40000));
    pick = $urandom_range(0, 15);
    if (pick < 2) sa = CFG_DATA_BITS'(1);
    else if (pick == 2) sa = '0;
    else if (pick == 3) sa = CFG_DATA_BITS'($urandom_range(1, 131071));
    else sa = CFG_DATA_BITS'($urandom_range(1, 4000));
    if ($urandom_range(0, 4) == 0) begin
      // any order, full width, upper bit masked off by the block
      rt = CFG_DATA_BITS'($urandom);
      ht = CFG_DATA_BITS'($urandom);
      tt = CFG_DATA_BITS'($urandom);
    end else begin
      rt = CFG_DATA_BITS'($urandom_range(200, 320));
      ht = rt + CFG_DATA_BITS'($urandom_range(0, 200));
      tt = ht + CFG_DATA_BITS'($urandom_range(0, 400));
      rt[CFG_DATA_BITS-1] = 1'($urandom_range(0, 1));
      ht[CFG_DATA_BITS-1] = 1'($urandom_range(0, 1));
      tt[CFG_DATA_BITS-1] = 1'($urandom_range(0, 1));
    end
    program_regs(fa, sa, rt, ht, tt);
  endtask

  initial begin
    int base_lvl;
    int kind;
    int seg_len;
    int sent;
    logic [SAMPLE_BITS-1:0] s;

    chk = new();
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    samples_if.valid = 1'b0;
    samples_if.sample = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero baseline first, then full scale steps
    send_sample(12'd0);
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd4095);
    send_sample(12'd4095);
    send_sample(12'd1);
    send_sample(12'd2048);
    send_sample(12'd0);
    drain();

    // alpha of one, minimal baseline alpha, all thresholds zero
    program_regs(CFG_DATA_BITS'(65536), CFG_DATA_BITS'(1), '0, '0, '0);
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd4095);
    drain();

    // alpha above one saturates, baseline frozen, thresholds out of order
    program_regs('1, '0, '1, '0, CFG_DATA_BITS'(256));
    send_sample(12'd2048);
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd1);
    drain();

    // fast average frozen, baseline follows directly, descending thresholds
    program_regs('0, CFG_DATA_BITS'(65536), CFG_DATA_BITS'(768), CFG_DATA_BITS'(384),
                 CFG_DATA_BITS'(256));
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd2048);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 1)
        program_regs(CFG_DATA_BITS'(6554), CFG_DATA_BITS'(66), CFG_DATA_BITS'(307),
                     CFG_DATA_BITS'(384), CFG_DATA_BITS'(512));
      else
        random_config();
      if (phase == 3) long_hold_req = 1'b1;
      if (phase == 7) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      sent = 0;
      while (sent < 104) begin
        kind = $urandom_range(0, 9);
        seg_len = $urandom_range(5, 30);
        base_lvl = $urandom_range(50, 1500);
        for (int i = 0; i < seg_len && sent < 104; i++) begin
          case (kind)
            0, 1, 2, 3, 4, 5: s = clamp_sample(base_lvl + $urandom_range(0, 64) - 32);
            6, 7:             s = clamp_sample(base_lvl * $urandom_range(2, 5));
            8:                s = SAMPLE_BITS'($urandom_range(0, 4095));
            default:          s = $urandom_range(0, 1) ? '1 : '0;
          endcase
          send_sample(s);
          sent++;
          // sender pause until everything is out
          if (phase == 5 && sent == 50) drain();
        end
      end
      drain();
    end

    if (chk.errors == 0 && chk.pending() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
